// ===== sv/ipa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipa_pkg: shared types and constants for the padded ASCII integer formatter
// Job descriptor between front and back, state encodings, character codes.
// ----------------------------------------------------------------------------
package ipa_pkg;

  localparam int MAG_W       = 64;
  localparam int FW_W        = 6;
  localparam int MAX_WIDTH   = 63;
  localparam int DIGIT_SLOTS = 21;
  localparam int HEX_DIGITS  = MAG_W / 4;
  localparam int IDX_W       = $clog2(DIGIT_SLOTS);
  localparam int PAD_W       = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W       = (PAD_W > FW_W) ? PAD_W : FW_W;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h41;

  typedef logic [DIGIT_SLOTS-1:0][3:0] digits_t;

  // One formatted number waiting for the back end
  typedef struct packed {
    digits_t          digits;
    logic [IDX_W-1:0] msd_idx;
    logic             negative;
    logic             zero_pad;
    logic             flush_left;
    logic [PAD_W-1:0] pad;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_SCAN,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_LEAD,
    B_SIGN,
    B_ZPAD,
    B_DIGITS,
    B_TRAIL
  } back_state_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {4'd0, d};
    end else begin
      c = CHAR_A + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage : ipa_pkg
`default_nettype wire

// ===== sv/ipa_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipa_front: item intake and digit extraction
// Double-dabble (two bits a cycle) for decimal, nibble split for hex, then a
// downward scan for the most significant digit and the pad count.
// ----------------------------------------------------------------------------
module ipa_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [63:0]           in_magnitude,
  input  wire logic                  in_hex_mode,
  input  wire logic                  in_negative,
  input  wire logic [5:0]            in_field_width,
  input  wire logic                  in_zero_pad,
  input  wire logic                  in_flush_left,
  input  wire ipa_pkg::q_status_t    q_status,
  output logic                       q_push,
  output ipa_pkg::job_t              q_job
);
  import ipa_pkg::*;

  localparam int CONV_STEPS = MAG_W / 2;
  localparam int CONV_W     = $clog2(CONV_STEPS);

  front_state_t      state_r, state_nxt;
  logic [MAG_W-1:0]  mag_r, mag_nxt;
  digits_t           digits_r, digits_nxt;
  logic [CONV_W-1:0] conv_cnt_r, conv_cnt_nxt;
  logic [IDX_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic              neg_r, neg_nxt;
  logic [FW_W-1:0]   fw_r, fw_nxt;
  logic              zpad_r, zpad_nxt;
  logic              left_r, left_nxt;

  logic [CMP_W-1:0]  width_sat;
  logic [CMP_W-1:0]  text_len;

  // one shift-and-correct step of binary to BCD
  function automatic digits_t dabble(input digits_t b, input logic bit_in);
    digits_t                      adj;
    logic [DIGIT_SLOTS*4-1:0]     v;
    for (int i = 0; i < DIGIT_SLOTS; i++) begin
      adj[i] = (b[i] >= 4'd5) ? b[i] + 4'd3 : b[i];
    end
    v = adj;
    v = {v[DIGIT_SLOTS*4-2:0], bit_in};
    return digits_t'(v);
  endfunction

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (start) begin
          state_nxt = in_hex_mode ? F_SCAN : F_CONV;
        end
      end
      F_CONV: begin
        if (conv_cnt_r == CONV_W'(CONV_STEPS - 1)) begin
          state_nxt = F_SCAN;
        end
      end
      F_SCAN: begin
        if (digits_r[scan_idx_r] != 4'd0 || scan_idx_r == '0) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_status.full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    mag_nxt      = mag_r;
    digits_nxt   = digits_r;
    conv_cnt_nxt = conv_cnt_r;
    scan_idx_nxt = scan_idx_r;
    neg_nxt      = neg_r;
    fw_nxt       = fw_r;
    zpad_nxt     = zpad_r;
    left_nxt     = left_r;
    case (state_r)
      F_IDLE: begin
        if (start) begin
          mag_nxt      = in_magnitude;
          neg_nxt      = in_negative;
          fw_nxt       = in_field_width;
          zpad_nxt     = in_zero_pad;
          left_nxt     = in_flush_left;
          conv_cnt_nxt = '0;
          digits_nxt   = '0;
          if (in_hex_mode) begin
            for (int i = 0; i < HEX_DIGITS; i++) begin
              digits_nxt[i] = in_magnitude[i*4 +: 4];
            end
            scan_idx_nxt = IDX_W'(HEX_DIGITS - 1);
          end else begin
            scan_idx_nxt = IDX_W'(DIGIT_SLOTS - 1);
          end
        end
      end
      F_CONV: begin
        digits_nxt   = dabble(dabble(digits_r, mag_r[MAG_W-1]), mag_r[MAG_W-2]);
        mag_nxt      = {mag_r[MAG_W-3:0], 2'b00};
        conv_cnt_nxt = conv_cnt_r + 1'b1;
      end
      F_SCAN: begin
        if (digits_r[scan_idx_r] == 4'd0 && scan_idx_r != '0) begin
          scan_idx_nxt = scan_idx_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // width saturation and pad count
  always_comb begin
    width_sat = (CMP_W'(fw_r) > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : CMP_W'(fw_r);
    text_len  = CMP_W'(scan_idx_r) + CMP_W'(1) + CMP_W'(neg_r);
  end

  // outputs
  always_comb begin
    busy             = (state_r != F_IDLE);
    q_push           = (state_r == F_PUSH) && !q_status.full;
    q_job.digits     = digits_r;
    q_job.msd_idx    = scan_idx_r;
    q_job.negative   = neg_r;
    q_job.zero_pad   = zpad_r;
    q_job.flush_left = left_r;
    q_job.pad        = (width_sat > text_len) ? PAD_W'(width_sat - text_len) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    digits_r   <= digits_nxt;
    conv_cnt_r <= conv_cnt_nxt;
    scan_idx_r <= scan_idx_nxt;
    neg_r      <= neg_nxt;
    fw_r       <= fw_nxt;
    zpad_r     <= zpad_nxt;
    left_r     <= left_nxt;
  end

endmodule : ipa_front
`default_nettype wire

// ===== sv/ipa_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipa_queue: two-entry job queue
// Decouples digit extraction from character output.
// ----------------------------------------------------------------------------
module ipa_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire ipa_pkg::job_t      push_job,
  input  wire logic               pop,
  output ipa_pkg::job_t           pop_job,
  output ipa_pkg::q_status_t      status
);
  import ipa_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  always_comb begin
    do_push      = push && (count_r != CNT_W'(DEPTH));
    do_pop       = pop && (count_r != '0);
    wr_ptr_nxt   = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt   = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt    = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
    status.empty = (count_r == '0);
    status.full  = (count_r == CNT_W'(DEPTH));
    pop_job      = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule : ipa_queue
`default_nettype wire

// ===== sv/ipa_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipa_back: character sequencer
// Walks lead pad, sign, zero pad, digits and trailing pad, one char a cycle.
// ----------------------------------------------------------------------------
module ipa_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ipa_pkg::job_t      q_job,
  input  wire ipa_pkg::q_status_t q_status,
  output logic                    q_pop,
  output logic                    out_valid,
  output logic [7:0]              out_char,
  output logic                    out_last
);
  import ipa_pkg::*;

  back_state_t      state_r, state_nxt;
  job_t             job_r, job_nxt;
  logic [PAD_W-1:0] pad_cnt_r, pad_cnt_nxt;
  logic [IDX_W-1:0] dig_idx_r, dig_idx_nxt;

  logic             zpad_run;
  logic             trail_run;
  logic             pad_end;
  back_state_t      first_state;

  always_comb begin
    zpad_run  = !job_r.flush_left && job_r.zero_pad && (pad_cnt_r != '0);
    trail_run = job_r.flush_left && (pad_cnt_r != '0);
    pad_end   = (pad_cnt_r == PAD_W'(1));
    q_pop     = (state_r == B_IDLE) && !q_status.empty;

    if (q_job.flush_left) begin
      first_state = q_job.negative ? B_SIGN : B_DIGITS;
    end else if (!q_job.zero_pad && q_job.pad != '0) begin
      first_state = B_LEAD;
    end else if (q_job.negative) begin
      first_state = B_SIGN;
    end else if (q_job.zero_pad && q_job.pad != '0) begin
      first_state = B_ZPAD;
    end else begin
      first_state = B_DIGITS;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:   if (!q_status.empty) state_nxt = first_state;
      B_LEAD:   if (pad_end) state_nxt = job_r.negative ? B_SIGN : B_DIGITS;
      B_SIGN:   state_nxt = zpad_run ? B_ZPAD : B_DIGITS;
      B_ZPAD:   if (pad_end) state_nxt = B_DIGITS;
      B_DIGITS: if (dig_idx_r == '0) state_nxt = trail_run ? B_TRAIL : B_IDLE;
      B_TRAIL:  if (pad_end) state_nxt = B_IDLE;
      default:  state_nxt = B_IDLE;
    endcase
  end

  // counters and job register
  always_comb begin
    job_nxt     = job_r;
    pad_cnt_nxt = pad_cnt_r;
    dig_idx_nxt = dig_idx_r;
    case (state_r)
      B_IDLE: begin
        if (q_pop) begin
          job_nxt     = q_job;
          pad_cnt_nxt = q_job.pad;
          dig_idx_nxt = q_job.msd_idx;
        end
      end
      B_LEAD, B_ZPAD, B_TRAIL: pad_cnt_nxt = pad_cnt_r - 1'b1;
      B_DIGITS: if (dig_idx_r != '0) dig_idx_nxt = dig_idx_r - 1'b1;
      default: begin
      end
    endcase
  end

  // outputs
  always_comb begin
    out_valid = 1'b1;
    out_char  = CHAR_SPACE;
    out_last  = 1'b0;
    case (state_r)
      B_IDLE: begin
        out_valid = 1'b0;
      end
      B_LEAD: begin
        out_char = CHAR_SPACE;
      end
      B_SIGN: begin
        out_char = CHAR_MINUS;
      end
      B_ZPAD: begin
        out_char = CHAR_ZERO;
      end
      B_DIGITS: begin
        out_char = digit_char(job_r.digits[dig_idx_r]);
        out_last = (dig_idx_r == '0) && !trail_run;
      end
      B_TRAIL: begin
        out_char = CHAR_SPACE;
        out_last = pad_end;
      end
      default: begin
        out_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r     <= job_nxt;
    pad_cnt_r <= pad_cnt_nxt;
    dig_idx_r <= dig_idx_nxt;
  end

  a_last_ends_number : assert property (@(posedge clk) disable iff (!rst_n)
    out_last |=> !out_valid)
    else $error("character emitted straight after final character");

  a_sign_then_body : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_SIGN) |=> (state_r == B_ZPAD || state_r == B_DIGITS))
    else $error("sign not followed by zero pad or digits");

  a_pad_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_LEAD || state_r == B_ZPAD || state_r == B_TRAIL) |-> pad_cnt_r != '0)
    else $error("pad run with empty pad count");

  a_pop_only_idle : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r != B_IDLE)
    else $error("job taken but sequencer stayed idle");

endmodule : ipa_back
`default_nettype wire

// ===== sv/integer_to_padded_ascii.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_padded_ascii: printf-style integer to padded ASCII text
// Formats a 64-bit magnitude in decimal or upper-case hex with sign and
// field-width padding, one character per output transfer.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel: drive in_* and raise start; the transfer happens on a
//    clock edge with start high and busy low.
//  - Output channel: out_valid marks each character for one cycle; out_last
//    flags the final character of a number. The receiver cannot stall, so
//    every strobed character is taken on that cycle.
//  - Front end: decimal conversion is double-dabble at two bits a cycle,
//    hex is a direct nibble split; a downward scan then finds the leading
//    digit, and the job is handed on from a push state. busy is high from
//    the accepting edge until the job is handed on, and longer while the
//    queue is full.
//  - Back end: one character a cycle, and it passes through its idle state
//    between numbers, where it takes the next job from the queue.
//  - A two-entry job queue between them lets the next number convert while
//    the previous one is still being sent.
//  - With the back end idle, a handed-on job passes the queue count register
//    and the back end's idle state before its first character. The slower
//    of the two ends sets the sustained rate per number.
//  - Reset clears both sequencers and the queue; nothing is kept between
//    numbers.
// ----------------------------------------------------------------------------
module integer_to_padded_ascii (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] in_magnitude,
  input  wire logic        in_hex_mode,
  input  wire logic        in_negative,
  input  wire logic [5:0]  in_field_width,
  input  wire logic        in_zero_pad,
  input  wire logic        in_flush_left,
  output logic             out_valid,
  output logic [7:0]       out_char,
  output logic             out_last
);
  import ipa_pkg::*;

  // job hand-over between front and back
  job_t      push_job;
  job_t      pop_job;
  logic      q_push;
  logic      q_pop;
  q_status_t q_status;

  // front: accepts the transfer, extracts digits, works out the padding
  ipa_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_magnitude   (in_magnitude),
    .in_hex_mode    (in_hex_mode),
    .in_negative    (in_negative),
    .in_field_width (in_field_width),
    .in_zero_pad    (in_zero_pad),
    .in_flush_left  (in_flush_left),
    .q_status       (q_status),
    .q_push         (q_push),
    .q_job          (push_job)
  );

  // short queue so either side can wait independently
  ipa_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .status   (q_status)
  );

  // back: streams the characters out
  ipa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_job     (pop_job),
    .q_status  (q_status),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_char  (out_char),
    .out_last  (out_last)
  );

endmodule : integer_to_padded_ascii
`default_nettype wire
